>>> rtl/core/mbe_pkg.sv
package mbe_pkg;

   // fixed point format: Q4.28
   localparam int unsigned FRAC_BITS = 28;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_REAL_ORIGIN    = 3'd0;
   localparam csr_index_type REG_IMAG_ORIGIN    = 3'd1;
   localparam csr_index_type REG_REAL_STEP      = 3'd2;
   localparam csr_index_type REG_IMAG_STEP      = 3'd3;
   localparam csr_index_type REG_ESCAPE_LIMIT   = 3'd4;
   localparam csr_index_type REG_MAX_ITERATIONS = 3'd5;

   // reset values
   localparam logic signed [31:0] REAL_ORIGIN_RST    = -32'sd536870912;
   localparam logic signed [31:0] IMAG_ORIGIN_RST    = -32'sd402653184;
   localparam logic signed [31:0] REAL_STEP_RST      = 32'sd786432;
   localparam logic signed [31:0] IMAG_STEP_RST      = 32'sd786432;
   localparam logic [30:0]        ESCAPE_LIMIT_RST   = 31'd1073741824;
   localparam logic [15:0]        MAX_ITERATIONS_RST = 16'd256;

   // settings seen by the iteration engine
   typedef struct packed {
      logic signed [31:0] real_origin;
      logic signed [31:0] imag_origin;
      logic signed [31:0] real_step;
      logic signed [31:0] imag_step;
      logic [30:0]        escape_limit;
      logic [15:0]        max_iterations;
   } cfg_type;

   // operands for the shared multiplier
   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
   } mul_op_type;

   // clamp a wide signed value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time pixel engine.
// Request channel: req_valid/req_stall with req_col_index and req_row_index
// (10 bits each); a word is taken on a clock edge with req_valid high and
// req_stall low. The row scales real_step, the column scales imag_step.
// Response channel: rsp_valid/rsp_stall with rsp_shade (4 bits): 0 when the
// iteration cap was reached, else the iteration count modulo 16.
// Register port: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
// always high. Write registers only while no pixel is in flight.
// Sequence: c is formed in states S_CX, S_CY and S_CYW, then each
// iteration runs S_UPD, S_SQX, S_SQY and S_MAG. One 32x32 multiplier is
// shared for c and for the three products of each iteration (x*y, x*x, y*y).
// One pixel is worked on at a time: req_stall is high from the accept until
// the result is moved into the output register.
// A result waiting under rsp_stall holds; the finished pixel after it waits
// in the engine and the request side stays stalled.
// Reset: synchronous, clears the sequencer and response valid and loads the
// register defaults (-2.0, -1.5, 3/1024, 3/1024, 4.0, 256).
module mandelbrot_escape_pixel
   import mbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [9:0]    req_col_index,
   input  logic [9:0]    req_row_index,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [3:0]    rsp_shade,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_data
);

   cfg_type            cfg;
   mul_op_type         mul_op;
   logic signed [63:0] mul_product;

   // configuration registers
   mbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // shared multiplier
   mbe_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .product (mul_product)
   );

   // iteration sequencer
   mbe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_col_index (req_col_index),
      .req_row_index (req_row_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_shade     (rsp_shade),
      .mul_op        (mul_op),
      .mul_product   (mul_product)
   );

endmodule

>>> rtl/core/mbe_csr.sv
module mbe_csr
   import mbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_data,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_REAL_ORIGIN:    cfg_in.real_origin    = $signed(csr_data);
            REG_IMAG_ORIGIN:    cfg_in.imag_origin    = $signed(csr_data);
            REG_REAL_STEP:      cfg_in.real_step      = $signed(csr_data);
            REG_IMAG_STEP:      cfg_in.imag_step      = $signed(csr_data);
            REG_ESCAPE_LIMIT:   cfg_in.escape_limit   = csr_data[30:0];
            REG_MAX_ITERATIONS: cfg_in.max_iterations = csr_data[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.real_origin    <= REAL_ORIGIN_RST;
         cfg_ff.imag_origin    <= IMAG_ORIGIN_RST;
         cfg_ff.real_step      <= REAL_STEP_RST;
         cfg_ff.imag_step      <= IMAG_STEP_RST;
         cfg_ff.escape_limit   <= ESCAPE_LIMIT_RST;
         cfg_ff.max_iterations <= MAX_ITERATIONS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/mbe_mul.sv
module mbe_mul
   import mbe_pkg::*;
(
   input  logic               clock,
   input  mul_op_type         op,
   output logic signed [63:0] product
);

   logic signed [63:0] product_ff;
   logic signed [63:0] product_in;

   // one signed 32x32 product per cycle, registered
   assign product_in = op.a * op.b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

>>> rtl/core/mbe_ctrl.sv
module mbe_ctrl
   import mbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [9:0]         req_col_index,
   input  logic [9:0]         req_row_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_shade,
   output mul_op_type         mul_op,
   input  logic signed [63:0] mul_product
);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CX   = 3'd1;
   localparam logic [2:0] S_CY   = 3'd2;
   localparam logic [2:0] S_CYW  = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;
   localparam logic [2:0] S_SQX  = 3'd5;
   localparam logic [2:0] S_SQY  = 3'd6;
   localparam logic [2:0] S_MAG  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic               done_ff, done_in;
   logic [9:0]         col_ff, col_in;
   logic [9:0]         row_ff, row_in;
   logic signed [31:0] cx_ff, cx_in;
   logic signed [31:0] cy_ff, cy_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [63:0] xx_ff, xx_in;
   logic signed [63:0] yy_keep_ff, yy_keep_in;
   logic [15:0]        k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         shade_ff, shade_in;

   logic               accept;
   logic               out_free;
   logic signed [63:0] re_sum;
   logic signed [63:0] im_sum;
   logic [63:0]        mag_sum;
   logic [30:0]        mag;
   logic               finished;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // new z from x*x - y*y and 2*x*y, floor shifted
   assign re_sum = ((xx_ff - yy_keep_ff) >>> FRAC_BITS) + 64'(cx_ff);
   assign im_sum = (mul_product >>> (FRAC_BITS - 1)) + 64'(cy_ff);

   // squared magnitude of new z, saturating
   assign mag_sum = 64'(xx_ff) + 64'(mul_product);
   assign mag     = (mag_sum[63:59] != 5'd0) ? 31'h7FFFFFFF : mag_sum[58:28];
   assign finished = (mag >= cfg.escape_limit) || (k_ff >= cfg.max_iterations);

   // operand selection for the shared multiplier
   always_comb begin
      mul_op.a = x_ff;
      mul_op.b = y_ff;
      unique case (state_ff)
         S_CX: begin
            mul_op.a = cfg.real_step;
            mul_op.b = $signed({22'd0, row_ff});
         end
         S_CY: begin
            mul_op.a = cfg.imag_step;
            mul_op.b = $signed({22'd0, col_ff});
         end
         S_SQX: begin
            mul_op.a = x_ff;
            mul_op.b = x_ff;
         end
         S_SQY: begin
            mul_op.a = y_ff;
            mul_op.b = y_ff;
         end
         default: begin
            mul_op.a = x_ff;
            mul_op.b = y_ff;
         end
      endcase
   end

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xx_in        = xx_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      shade_in     = shade_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (done_ff) begin
               // hand the word over once the output register is free
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  shade_in     = (k_ff >= cfg.max_iterations) ? 4'd0 : k_ff[3:0];
                  done_in      = 1'b0;
               end
            end else if (accept) begin
               col_in   = req_col_index;
               row_in   = req_row_index;
               x_in     = '0;
               y_in     = '0;
               xx_in    = '0;
               state_in = S_CX;
            end
         end
         S_CX: begin
            state_in = S_CY;
         end
         S_CY: begin
            cx_in    = sat32(mul_product + 64'(cfg.real_origin));
            state_in = S_CYW;
         end
         S_CYW: begin
            cy_in    = sat32(mul_product + 64'(cfg.imag_origin));
            k_in     = '0;
            state_in = S_UPD;
         end
         S_UPD: begin
            x_in     = sat32(re_sum);
            y_in     = sat32(im_sum);
            k_in     = k_ff + 16'd1;
            state_in = S_SQX;
         end
         S_SQX: begin
            state_in = S_SQY;
         end
         S_SQY: begin
            xx_in    = mul_product;
            state_in = S_MAG;
         end
         S_MAG: begin
            // product holds y*y here; the next x*y is already issued
            if (finished) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_UPD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // the y*y product becomes the subtrahend of the next update, zero for a new pixel
   assign yy_keep_in = (state_ff == S_MAG) ? mul_product : (accept ? '0 : yy_keep_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      row_ff     <= row_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      xx_ff      <= xx_in;
      k_ff       <= k_in;
      shade_ff   <= shade_in;
      yy_keep_ff <= yy_keep_in;
   end

   assign req_stall = (state_ff != S_IDLE) || done_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_shade = shade_ff;

`ifndef SYNTHESIS
   // an accepted word starts the c computation
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CX))
      else $error("accepted word did not start the sequence");

   // a finished iteration leaves the loop
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAG) && finished |=> (state_ff == S_IDLE) && done_ff)
      else $error("finished iteration did not end the loop");

   // a result only appears after a finished pixel
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(done_ff))
      else $error("result raised without a finished pixel");

   // no new word is taken while a pixel is pending hand-over
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> req_stall)
      else $error("input taken while a result is pending");
`endif

endmodule
